/* src/sector_cache_tax_replacement_assert.svh */
// Assertion macros for the sector cache RTL.
// No dependencies; included by modules that check their own logic.
`ifndef SECTOR_CACHE_TAX_REPLACEMENT_ASSERT_SVH
`define SECTOR_CACHE_TAX_REPLACEMENT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication or plain property, checked out of reset.
`define SCTR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sector cache assertion failed");
// Condition that must never be seen out of reset.
`define SCTR_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("sector cache forbidden condition");
`else
`define SCTR_ASSERT(lbl, clk, rstn, prop)
`define SCTR_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* src/sctr_pkg.sv */
// Shared types, codes and saturating tax arithmetic for the sector cache.
// No dependencies.
package sctr_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 4;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [1:0] KIND_FINAL = 2'd0;
    localparam logic [1:0] KIND_WB    = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_NOSEC = 2'd2;

    localparam logic [31:0] BASE_RST = 32'hFFFF_FFF0;
    localparam logic signed [31:0] MIN_START = 32'sh0FFF_FFFF;

    typedef logic signed [31:0] t_tax;

    typedef struct packed {
        logic [31:0] base;
        t_tax        tax;
        logic        dirty;
    } t_entry;

    localparam t_entry ENTRY_RST = '{base: BASE_RST, tax: 32'sd0, dirty: 1'b0};

    function automatic t_tax tax_add(input t_tax t, input logic signed [32:0] d);
        logic signed [32:0] v;
        v = $signed({t[31], t}) + d;
        if (v > 33'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

/* src/sctr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sctr_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/sctr_rem.sv */
// Remainder of a 32-bit sector number by a constant divisor: byte residues are registered, then the folded remainder.
// Byte residues come from constant tables and a small table folds their sum.
// Depends on sctr_pkg.
module sctr_rem import sctr_pkg::*; #(
    parameter int MAX = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DATA_W-1:0]          i_value,
    output logic                       o_done,
    output logic [$clog2(MAX+1)-1:0]   o_rem
);
    localparam int RW = $clog2(MAX + 1);

    typedef logic [255:0][RW-1:0] t_byte_tab;
    typedef logic [31:0][RW-1:0]  t_fold_tab;

    // Residue of b * 256^k for every byte value b.
    function automatic t_byte_tab byte_tab(input int k);
        t_byte_tab t;
        int        w;
        w = 1 % MAX;
        for (int j = 0; j < k; j++) begin
            w = (w * 256) % MAX;
        end
        for (int b = 0; b < 256; b++) begin
            t[b] = RW'((b * w) % MAX);
        end
        return t;
    endfunction

    // Residue of the sum of four byte residues, at most 28.
    function automatic t_fold_tab fold_tab();
        t_fold_tab t;
        for (int s = 0; s < 32; s++) begin
            t[s] = RW'(s % MAX);
        end
        return t;
    endfunction

    localparam t_byte_tab TAB0 = byte_tab(0);
    localparam t_byte_tab TAB1 = byte_tab(1);
    localparam t_byte_tab TAB2 = byte_tab(2);
    localparam t_byte_tab TAB3 = byte_tab(3);
    localparam t_fold_tab FOLD = fold_tab();

    logic               r_busy;
    logic [3:0][RW-1:0] r_part;
    logic [RW-1:0]      r_rem;
    logic [4:0]         sum;

    assign sum = 5'(r_part[0]) + 5'(r_part[1]) + 5'(r_part[2]) + 5'(r_part[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_part[0] <= TAB0[i_value[7:0]];
            r_part[1] <= TAB1[i_value[15:8]];
            r_part[2] <= TAB2[i_value[23:16]];
            r_part[3] <= TAB3[i_value[31:24]];
        end else if (r_busy) begin
            r_rem  <= FOLD[sum];
            r_busy <= 1'b0;
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem;
endmodule

/* src/sector_cache_tax_replacement.sv */
// Top level of the sector cache tag and replacement engine.
// Depends on sctr_pkg, sctr_ram, sctr_rem and the assertion macro header.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  command  | i_start / o_busy           | i_op, i_sector
//  result   | o_valid (strobe, no stall) | o_kind .. o_last
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (slot_shift)
//
// Read, alloc, write and nonempty flush sweep the slot RAM one slot per cycle, then
// strobe the final result. A miss passes a victim update state, then a writeback
// request state if the victim is dirty and a fill request state on a read.
// Flush writebacks strobe during the sweep; an empty flush skips the sweep.
// o_busy drops with the final result. Synchronous active-low reset clears control
// state and valid bits; RAM contents are ignored until written. No receiver stall.
`include "sector_cache_tax_replacement_assert.svh"
module sector_cache_tax_replacement import sctr_pkg::*; #(
    parameter int SLOTS                = 32,
    parameter int MAX_SECTORS_PER_SLOT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_sector,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [31:0] o_disk_sector,
    output logic [4:0]  o_slot_number,
    output logic [7:0]  o_buffer_index,
    output logic [5:0]  o_flush_count,
    output logic [31:0] o_access_total,
    output logic [31:0] o_hit_total,
    output logic        o_last
);
    localparam int IW = $clog2(SLOTS);
    localparam int RW = $clog2(MAX_SECTORS_PER_SLOT + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_WB, S_FILL, S_FIN} t_state;

    t_state      r_state;
    logic [1:0]  r_op;
    logic [31:0] r_sector;
    logic [1:0]  r_shift;
    logic [31:0] r_acc, r_hits, r_pend;
    logic [SLOTS-1:0] r_written, r_alloc;
    logic        r_issue, r_pv;
    logic [IW-1:0] r_ridx, r_pidx;
    logic        r_hit;
    logic [IW-1:0] r_hidx, r_vidx;
    logic [31:0] r_hbase, r_vbase;
    t_tax        r_htax, r_vtax, r_vmin;
    logic        r_vdirty;
    logic [5:0]  r_fcnt;

    logic        accept;
    logic [EW-1:0] ram_rdata;
    logic        ram_we;
    logic [IW-1:0] ram_wa;
    t_entry      ram_wd, cur;
    logic [LEN_W-1:0] pow, maxl, lw, rem_l;
    logic        use_mask, match, scan_last, rem_done;
    logic [31:0] diff, aligned;
    t_tax        t_hit0, nt;
    logic [RW-1:0] rem_u;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_access_total = r_acc;
    assign o_hit_total    = r_hits;

    // Sectors per slot: a power of two capped by the parameter.
    assign pow      = LEN_W'(1) << r_shift;
    assign maxl     = LEN_W'(MAX_SECTORS_PER_SLOT);
    assign use_mask = (pow <= maxl);
    assign lw       = use_mask ? pow : maxl;
    assign rem_l    = use_mask ? (r_sector[LEN_W-1:0] & (pow - LEN_W'(1))) : LEN_W'(rem_u);
    assign aligned  = r_sector - 32'(rem_l);

    sctr_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (r_ridx),
        .o_rdata (ram_rdata)
    );

    sctr_rem #(.MAX(MAX_SECTORS_PER_SLOT)) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_op == OP_READ || i_op == OP_ALLOC)),
        .i_value (i_sector),
        .o_done  (rem_done),
        .o_rem   (rem_u)
    );

    // Slot under inspection; never-written entries read as their reset value.
    always_comb begin
        cur       = r_written[r_pidx] ? t_entry'(ram_rdata) : ENTRY_RST;
        diff      = r_sector - cur.base;
        match     = r_alloc[r_pidx] && (diff < 32'(lw));
        scan_last = r_pv && (r_pidx == IW'(SLOTS - 1));
        t_hit0    = (cur.tax < 0) ? 32'sd0 : cur.tax;
        nt        = match ? tax_add(tax_add(t_hit0, 33'sd2), -33'sd1)
                          : tax_add(cur.tax, -33'sd1);
    end

    // Write-back port: scan updates, victim rebase, write mark.
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_pidx;
        ram_wd = cur;
        case (r_state)
            S_SCAN: begin
                if (r_pv && (r_op == OP_READ || r_op == OP_ALLOC)) begin
                    ram_we     = 1'b1;
                    ram_wd.tax = nt;
                end else if (r_pv && r_op == OP_FLUSH && cur.dirty) begin
                    ram_we       = 1'b1;
                    ram_wd.dirty = 1'b0;
                end
            end
            S_WAIT: begin
                ram_wa = r_vidx;
                ram_wd = '{base: aligned, tax: tax_add(r_vtax, 33'sd2), dirty: 1'b0};
                ram_we = rem_done;
            end
            S_FIN: begin
                ram_wa = r_hidx;
                ram_wd = '{base: r_hbase, tax: tax_add(r_htax, 33'sd2), dirty: 1'b1};
                ram_we = (r_op == OP_WRITE) && r_hit;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_shift   <= 2'd3;
            r_acc     <= '0;
            r_hits    <= '0;
            r_pend    <= '0;
            r_written <= '0;
            r_alloc   <= '0;
            r_issue   <= 1'b0;
            r_pv      <= 1'b0;
            r_fcnt    <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_shift <= i_cfg_data;
            end
            if (ram_we) begin
                r_written[ram_wa] <= 1'b1;
            end
            // Advance the read sweep; data returns in the next cycle, alongside r_pv and r_pidx.
            r_pv   <= r_issue;
            r_pidx <= r_ridx;
            if (r_issue) begin
                r_ridx <= r_ridx + IW'(1);
                if (r_ridx == IW'(SLOTS - 1)) begin
                    r_issue <= 1'b0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_op;
                        r_sector <= i_sector;
                        r_hit    <= 1'b0;
                        r_vmin   <= MIN_START;
                        r_fcnt   <= '0;
                        if (i_op == OP_READ) begin
                            r_acc <= r_acc + 32'd1;
                        end
                        if (i_op == OP_FLUSH && r_pend == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_issue <= 1'b1;
                            r_ridx  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        case (r_op)
                            OP_READ, OP_ALLOC: begin
                                if (match) begin
                                    r_hit   <= 1'b1;
                                    r_hidx  <= r_pidx;
                                    r_hbase <= cur.base;
                                end
                                // First lowest tax wins; slot 0 by default.
                                if (nt < r_vmin || r_pidx == '0) begin
                                    r_vidx   <= r_pidx;
                                    r_vtax   <= nt;
                                    r_vdirty <= cur.dirty;
                                    r_vbase  <= cur.base;
                                end
                                if (nt < r_vmin) begin
                                    r_vmin <= nt;
                                end
                            end
                            OP_WRITE: begin
                                if (match && !r_hit) begin
                                    r_hit   <= 1'b1;
                                    r_hidx  <= r_pidx;
                                    r_hbase <= cur.base;
                                    r_htax  <= cur.tax;
                                end
                            end
                            default: begin
                                if (cur.dirty) begin
                                    o_valid        <= 1'b1;
                                    o_kind         <= KIND_WB;
                                    o_status       <= ST_OK;
                                    o_disk_sector  <= cur.base;
                                    o_slot_number  <= 5'(r_pidx);
                                    o_buffer_index <= '0;
                                    o_flush_count  <= '0;
                                    o_last         <= 1'b0;
                                    r_fcnt         <= r_fcnt + 6'd1;
                                end
                            end
                        endcase
                        if (scan_last) begin
                            if (r_op == OP_READ || r_op == OP_ALLOC) begin
                                if (r_hit || match) begin
                                    if (r_op == OP_READ) begin
                                        r_hits <= r_hits + 32'd1;
                                    end
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_WAIT;
                                end
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_WAIT: begin
                    if (rem_done) begin
                        r_alloc[r_vidx] <= 1'b1;
                        if (r_vdirty) begin
                            r_state <= S_WB;
                        end else if (r_op == OP_READ) begin
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_WB: begin
                    o_valid        <= 1'b1;
                    o_kind         <= KIND_WB;
                    o_status       <= ST_OK;
                    o_disk_sector  <= r_vbase;
                    o_slot_number  <= 5'(r_vidx);
                    o_buffer_index <= '0;
                    o_flush_count  <= '0;
                    o_last         <= 1'b0;
                    r_state        <= (r_op == OP_READ) ? S_FILL : S_FIN;
                end
                S_FILL: begin
                    o_valid        <= 1'b1;
                    o_kind         <= KIND_FILL;
                    o_status       <= ST_OK;
                    o_disk_sector  <= aligned;
                    o_slot_number  <= 5'(r_vidx);
                    o_buffer_index <= '0;
                    o_flush_count  <= '0;
                    o_last         <= 1'b0;
                    r_state        <= S_FIN;
                end
                S_FIN: begin
                    o_valid        <= 1'b1;
                    o_kind         <= KIND_FINAL;
                    o_status       <= ST_OK;
                    o_disk_sector  <= '0;
                    o_slot_number  <= '0;
                    o_buffer_index <= '0;
                    o_flush_count  <= '0;
                    o_last         <= 1'b1;
                    case (r_op)
                        OP_FLUSH: begin
                            o_flush_count <= r_fcnt;
                            r_pend        <= '0;
                        end
                        OP_WRITE: begin
                            if (r_hit) begin
                                o_slot_number <= 5'(r_hidx);
                                r_pend        <= r_pend + 32'd1;
                            end else begin
                                o_status <= ST_NOSEC;
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                o_slot_number  <= 5'(r_hidx);
                                o_buffer_index <= 8'(8'(r_hidx) * 8'(lw))
                                                  + 8'(r_sector - r_hbase);
                            end else begin
                                o_status       <= ST_MISS;
                                o_slot_number  <= 5'(r_vidx);
                                o_buffer_index <= 8'(8'(r_vidx) * 8'(lw)) + 8'(rem_l);
                            end
                        end
                    endcase
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SCTR_NEVER(a_idle_no_sweep, i_clk, i_rst_n, (!o_busy) && r_issue)
    `SCTR_ASSERT(a_last_gap, i_clk, i_rst_n, (o_valid && o_last) |=> !o_valid)
    `SCTR_ASSERT(a_pv_in_scan, i_clk, i_rst_n, r_pv |-> (r_state == S_SCAN))
    `SCTR_ASSERT(a_flush_bound, i_clk, i_rst_n, (r_fcnt <= 6'(SLOTS)))
endmodule

/* tb/sv/tb_sector_cache_tax_replacement.sv */
// Self-checking testbench for the sector cache tag and replacement engine.
// Depends on sctr_pkg and sector_cache_tax_replacement; predicts every result in-line.
`timescale 1ns / 100ps
module tb_sector_cache_tax_replacement;
    import sctr_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] sector;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] disk_sector;
        logic [4:0]  slot_number;
        logic [7:0]  buffer_index;
        logic [5:0]  flush_count;
        logic [31:0] access_total;
        logic [31:0] hit_total;
        logic        last;
    } t_answer;

    localparam int NSLOT = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  op = OP_READ;
    logic [31:0] sector = '0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = '0;
    logic        busy, cfg_ready, res_valid, res_last;
    logic [1:0]  res_kind, res_status;
    logic [31:0] res_disk_sector, res_access_total, res_hit_total;
    logic [4:0]  res_slot_number;
    logic [7:0]  res_buffer_index;
    logic [5:0]  res_flush_count;

    // Predictor copy of the cache state.
    logic [31:0] mdl_base [NSLOT];
    int          mdl_tax [NSLOT];
    bit          mdl_dirty [NSLOT];
    bit          mdl_valid [NSLOT];
    logic [31:0] mdl_pending, mdl_accesses, mdl_hits;
    logic [1:0]  mdl_shift;

    t_request    request_q[$];
    t_answer     expected_q[$];
    int          errors = 0;
    int          send_idle_pct = 14;
    bit          cfg_pending = 1'b0;
    logic [1:0]  cfg_value;
    bit          cfg_done = 1'b0;

    sector_cache_tax_replacement uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_op           (op),
        .i_sector       (sector),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_valid        (res_valid),
        .o_kind         (res_kind),
        .o_status       (res_status),
        .o_disk_sector  (res_disk_sector),
        .o_slot_number  (res_slot_number),
        .o_buffer_index (res_buffer_index),
        .o_flush_count  (res_flush_count),
        .o_access_total (res_access_total),
        .o_hit_total    (res_hit_total),
        .o_last         (res_last)
    );

    always #5 clk = ~clk;

    // Saturating signed add on the 32-bit tax.
    function automatic int sat_tax(int t, int d);
        longint v;
        v = longint'(t) + longint'(d);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return int'(v);
    endfunction

    function automatic void push_answer(logic [1:0] kind, logic [1:0] status,
            logic [31:0] dsec, int slot, int bidx, int fc, bit last);
        t_answer a;
        a.kind = kind;
        a.status = status;
        a.disk_sector = dsec;
        a.slot_number = slot[4:0];
        a.buffer_index = bidx[7:0];
        a.flush_count = fc[5:0];
        a.access_total = mdl_accesses;
        a.hit_total = mdl_hits;
        a.last = last;
        expected_q.push_back(a);
    endfunction

    function automatic void predict_cache(t_request r);
        int          span, hit, victim, cnt, mint;
        logic [31:0] offs, aligned;
        span = 1 << mdl_shift;
        if (span > 8) span = 8;
        hit = -1;
        if (r.op == OP_FLUSH) begin
            cnt = 0;
            if (mdl_pending != 0) begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (mdl_dirty[i]) begin
                        push_answer(KIND_WB, ST_OK, mdl_base[i], i, 0, 0, 1'b0);
                        mdl_dirty[i] = 1'b0;
                        cnt++;
                    end
                end
                mdl_pending = 0;
            end
            push_answer(KIND_FINAL, ST_OK, 0, 0, 0, cnt, 1'b1);
            return;
        end
        if (r.op == OP_WRITE) begin
            // Write marks the first matching slot.
            for (int i = 0; i < NSLOT; i++) begin
                offs = r.sector - mdl_base[i];
                if (mdl_valid[i] && offs < span) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                push_answer(KIND_FINAL, ST_NOSEC, 0, 0, 0, 0, 1'b1);
                return;
            end
            mdl_tax[hit] = sat_tax(mdl_tax[hit], 2);
            mdl_dirty[hit] = 1'b1;
            mdl_pending++;
            push_answer(KIND_FINAL, ST_OK, 0, hit, 0, 0, 1'b1);
            return;
        end
        if (r.op == OP_READ) mdl_accesses++;
        // Every match gets the bonus; the last match answers; all slots decay.
        for (int i = 0; i < NSLOT; i++) begin
            offs = r.sector - mdl_base[i];
            if (mdl_valid[i] && offs < span) begin
                if (mdl_tax[i] < 0) mdl_tax[i] = 0;
                mdl_tax[i] = sat_tax(mdl_tax[i], 2);
                hit = i;
            end
            mdl_tax[i] = sat_tax(mdl_tax[i], -1);
        end
        if (hit >= 0) begin
            if (r.op == OP_READ) mdl_hits++;
            offs = r.sector - mdl_base[hit];
            push_answer(KIND_FINAL, ST_OK, 0, hit, hit * span + int'(offs), 0, 1'b1);
            return;
        end
        victim = 0;
        mint = 32'h0FFF_FFFF;
        for (int i = 0; i < NSLOT; i++) begin
            if (mdl_tax[i] < mint) begin
                victim = i;
                mint = mdl_tax[i];
            end
        end
        aligned = r.sector & ~(32'(span) - 1);
        if (mdl_dirty[victim]) begin
            push_answer(KIND_WB, ST_OK, mdl_base[victim], victim, 0, 0, 1'b0);
            mdl_dirty[victim] = 1'b0;
        end
        mdl_tax[victim] = sat_tax(mdl_tax[victim], 2);
        mdl_base[victim] = aligned;
        mdl_valid[victim] = 1'b1;
        if (r.op == OP_READ) push_answer(KIND_FILL, ST_OK, aligned, victim, 0, 0, 1'b0);
        push_answer(KIND_FINAL, ST_MISS, 0, victim,
                    victim * span + int'(r.sector - aligned), 0, 1'b1);
    endfunction

    // Driver: hold start until the block takes the request, predict at acceptance.
    // The predictor state is reset here and follows every accepted config write.
    always @(posedge clk) begin
        if (!rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                mdl_base[i] = BASE_RST;
                mdl_tax[i] = 0;
                mdl_dirty[i] = 1'b0;
                mdl_valid[i] = 1'b0;
            end
            mdl_pending = 0;
            mdl_accesses = 0;
            mdl_hits = 0;
            mdl_shift = 2'd3;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mdl_shift = cfg_data;
            end
            if (start && !busy) begin
                predict_cache('{op: op, sector: sector});
            end
            if (!(start && busy)) begin
                if (request_q.size() != 0 && !cfg_pending
                        && $urandom_range(99) >= send_idle_pct) begin
                    t_request r;
                    r = request_q.pop_front();
                    start <= 1'b1;
                    op <= r.op;
                    sector <= r.sector;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Configuration channel: write the slot shift when asked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                cfg_valid <= 1'b0;
                cfg_done <= 1'b1;
            end else if (!cfg_pending) begin
                cfg_done <= 1'b0;
            end else if (!cfg_valid && !cfg_done) begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_value;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && res_valid) begin
            t_answer got, want;
            got = '{res_kind, res_status, res_disk_sector, res_slot_number,
                    res_buffer_index, res_flush_count, res_access_total,
                    res_hit_total, res_last};
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // Wait until the block has drained everything sent so far.
    task automatic drain_cache();
        while (request_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_shift(logic [1:0] v);
        drain_cache();
        cfg_value = v;
        cfg_pending = 1'b1;
        while (!cfg_done) @(posedge clk);
        cfg_pending = 1'b0;
    endtask

    function automatic void queue_request(logic [1:0] o, logic [31:0] s);
        request_q.push_back('{op: o, sector: s});
    endfunction

    // Random sector near a small working set, with some full-range noise.
    function automatic logic [31:0] pick_sector();
        if ($urandom_range(9) == 0) return $urandom();
        return 32'h1000 + $urandom_range(200);
    endfunction

    task automatic random_phase(int n);
        int c;
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(99);
            if (c < 45) queue_request(OP_READ, pick_sector());
            else if (c < 65) queue_request(OP_ALLOC, pick_sector());
            else if (c < 92) queue_request(OP_WRITE, pick_sector());
            else queue_request(OP_FLUSH, $urandom());
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flush when nothing is pending, write to unallocated, extremes.
        queue_request(OP_FLUSH, 32'h0);
        queue_request(OP_WRITE, 32'hFFFF_FFF0);
        queue_request(OP_READ, 32'hFFFF_FFFF);
        queue_request(OP_READ, 32'hFFFF_FFF8);
        queue_request(OP_WRITE, 32'hFFFF_FFFC);
        queue_request(OP_ALLOC, 32'h0000_0000);
        queue_request(OP_WRITE, 32'h0000_0007);
        queue_request(OP_READ, 32'h0000_0005);
        queue_request(OP_ALLOC, 32'hAAAA_5555);
        queue_request(OP_READ, 32'h5555_AAAA);
        queue_request(OP_FLUSH, 32'hFFFF_FFFF);
        for (int i = 0; i < 34; i++) queue_request(OP_READ, 32'h100 + 8 * i);
        queue_request(OP_WRITE, 32'h100);
        queue_request(OP_FLUSH, 32'h0);

        // Hold off the sender until every expectation has arrived.
        drain_cache();

        // Narrow slots, then overlapping matches after widening.
        write_shift(2'd0);
        random_phase(35);
        write_shift(2'd1);
        random_phase(35);
        send_idle_pct = 46;
        write_shift(2'd2);
        random_phase(35);
        write_shift(2'd3);
        random_phase(40);
        send_idle_pct = 0;
        random_phase(40);
        queue_request(OP_FLUSH, 32'h0);
        drain_cache();

        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/sctr_pkg.sv
src/sctr_ram.sv
src/sctr_rem.sv
src/sector_cache_tax_replacement.sv
tb/sv/tb_sector_cache_tax_replacement.sv
